// ===== rtl/core/rld_pkg.sv =====
// Package for the restricted linear deque: storage sizing, command and status
// codes, controller state type and the request and response payload structs.
// Has no dependencies; every other file in rtl/core refers to it by scoped names.
package rld_pkg;

   localparam int DEPTH     = 128;
   localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CAP_W     = 8;
   localparam int OCC_W     = 8;
   localparam int DATA_W    = 32;
   localparam int CSR_IDX_W = 1;
   localparam int CMP_W     = (((IDX_W + 1) > CAP_W) ? (IDX_W + 1) : CAP_W) + 1;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(128);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAPACITY = 1'b0,
      CSR_MODE     = 1'b1
   } csr_idx_type;

   typedef enum logic {
      MODE_INPUT_RESTRICTED  = 1'b0,
      MODE_OUTPUT_RESTRICTED = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      CMD_INSERT_REAR  = 2'd0,
      CMD_INSERT_FRONT = 2'd1,
      CMD_DELETE_FRONT = 2'd2,
      CMD_DELETE_REAR  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_FULL        = 2'd1,
      ST_EMPTY       = 2'd2,
      ST_NOT_ALLOWED = 2'd3
   } status_type;

   typedef enum logic {
      CTRL_IDLE = 1'b0,
      CTRL_RESP = 1'b1
   } ctrl_state_type;

   typedef struct packed {
      cmd_type            command;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] removed_value;
      logic [OCC_W-1:0]   occupancy;
   } rsp_type;

   typedef struct packed {
      logic exec;
   } dp_cmd_type;

endpackage

// ===== rtl/core/rld_ctrl.sv =====
// Controller state machine for the restricted linear deque: runs both
// handshakes and tells the datapath when to execute a transaction.
// Depends on rld_pkg.
module rld_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rld_pkg::dp_cmd_type dp_cmd
);

   rld_pkg::ctrl_state_type state_ff;
   rld_pkg::ctrl_state_type state_in;
   logic                    accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rld_pkg::CTRL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      rsp_valid   = (state_ff == rld_pkg::CTRL_RESP);
      req_stall   = rsp_valid && rsp_stall;
      accept      = req_valid && !req_stall;
      dp_cmd.exec = accept;
      state_in    = state_ff;
      unique case (state_ff)
         rld_pkg::CTRL_IDLE: begin
            if (accept) begin
               state_in = rld_pkg::CTRL_RESP;
            end
         end
         rld_pkg::CTRL_RESP: begin
            if (accept) begin
               state_in = rld_pkg::CTRL_RESP;
            end else if (!rsp_stall) begin
               state_in = rld_pkg::CTRL_IDLE;
            end
         end
         default: begin
            state_in = rld_pkg::CTRL_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/rld_datapath.sv =====
// Datapath for the restricted linear deque: configuration registers, front and
// rear indices, the element store and the response register.
// Depends on rld_pkg.
module rld_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  rld_pkg::dp_cmd_type             dp_cmd,
   input  rld_pkg::req_type                req_data,
   output rld_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [rld_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rld_pkg::CAP_W-1:0]       csr_wdata
);

   localparam int IW = rld_pkg::IDX_W;
   localparam int CW = rld_pkg::CMP_W;

   logic [rld_pkg::CAP_W-1:0]  capacity_ff;
   rld_pkg::mode_type          mode_ff;
   logic [IW-1:0]              front_ff;
   logic [IW-1:0]              front_in;
   logic [IW-1:0]              rear_ff;
   logic [IW-1:0]              rear_in;
   logic                       empty_ff;
   logic                       empty_in;
   logic [rld_pkg::DATA_W-1:0] store_ff [rld_pkg::DEPTH];
   logic [rld_pkg::DATA_W-1:0] rd_data_ff;
   rld_pkg::status_type        status_ff;
   rld_pkg::status_type        status_in;
   logic [rld_pkg::OCC_W-1:0]  occ_ff;
   logic                       del_ok_ff;
   logic                       del_ok_in;
   logic                       wr_en;
   logic [IW-1:0]              addr;
   logic [CW-1:0]              cap_ext;
   logic [CW-1:0]              usable;
   logic                       rear_full;
   logic                       forbidden;
   logic [IW:0]                occ_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= rld_pkg::CAPACITY_RESET;
         mode_ff     <= rld_pkg::MODE_INPUT_RESTRICTED;
      end else if (csr_we) begin
         unique case (rld_pkg::csr_idx_type'(csr_index))
            rld_pkg::CSR_CAPACITY: capacity_ff <= csr_wdata;
            rld_pkg::CSR_MODE:     mode_ff     <= rld_pkg::mode_type'(csr_wdata[0]);
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cap_ext = CW'(capacity_ff);
      if (capacity_ff == '0) begin
         usable = CW'(1);
      end else if (cap_ext > CW'(rld_pkg::DEPTH)) begin
         usable = CW'(rld_pkg::DEPTH);
      end else begin
         usable = cap_ext;
      end
      rear_full = (CW'(rear_ff) + CW'(1)) >= usable;
      forbidden = ((req_data.command == rld_pkg::CMD_INSERT_FRONT) &&
                   (mode_ff == rld_pkg::MODE_INPUT_RESTRICTED)) ||
                  ((req_data.command == rld_pkg::CMD_DELETE_REAR) &&
                   (mode_ff == rld_pkg::MODE_OUTPUT_RESTRICTED));

      front_in  = front_ff;
      rear_in   = rear_ff;
      empty_in  = empty_ff;
      status_in = rld_pkg::ST_OK;
      del_ok_in = 1'b0;
      wr_en     = 1'b0;
      addr      = front_ff;

      if (forbidden) begin
         status_in = rld_pkg::ST_NOT_ALLOWED;
      end else begin
         unique case (req_data.command)
            rld_pkg::CMD_INSERT_REAR: begin
               if (empty_ff) begin
                  front_in = '0;
                  rear_in  = '0;
                  empty_in = 1'b0;
                  addr     = '0;
                  wr_en    = 1'b1;
               end else if (rear_full) begin
                  status_in = rld_pkg::ST_FULL;
               end else begin
                  rear_in = rear_ff + IW'(1);
                  addr    = rear_ff + IW'(1);
                  wr_en   = 1'b1;
               end
            end
            rld_pkg::CMD_INSERT_FRONT: begin
               if (empty_ff) begin
                  front_in = '0;
                  rear_in  = '0;
                  empty_in = 1'b0;
                  addr     = '0;
                  wr_en    = 1'b1;
               end else if (front_ff == '0) begin
                  status_in = rld_pkg::ST_FULL;
               end else begin
                  front_in = front_ff - IW'(1);
                  addr     = front_ff - IW'(1);
                  wr_en    = 1'b1;
               end
            end
            rld_pkg::CMD_DELETE_FRONT: begin
               if (empty_ff) begin
                  status_in = rld_pkg::ST_EMPTY;
               end else begin
                  del_ok_in = 1'b1;
                  addr      = front_ff;
                  if (front_ff == rear_ff) begin
                     front_in = '0;
                     rear_in  = '0;
                     empty_in = 1'b1;
                  end else begin
                     front_in = front_ff + IW'(1);
                  end
               end
            end
            rld_pkg::CMD_DELETE_REAR: begin
               if (empty_ff) begin
                  status_in = rld_pkg::ST_EMPTY;
               end else begin
                  del_ok_in = 1'b1;
                  addr      = rear_ff;
                  if (front_ff == rear_ff) begin
                     front_in = '0;
                     rear_in  = '0;
                     empty_in = 1'b1;
                  end else begin
                     rear_in = rear_ff - IW'(1);
                  end
               end
            end
            default: begin
            end
         endcase
      end

      occ_full = empty_in ? '0 : ({1'b0, rear_in} - {1'b0, front_in} + (IW+1)'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         rear_ff  <= '0;
         empty_ff <= 1'b1;
      end else if (dp_cmd.exec) begin
         front_ff <= front_in;
         rear_ff  <= rear_in;
         empty_ff <= empty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.exec) begin
         if (wr_en) begin
            store_ff[addr] <= req_data.value;
         end
         rd_data_ff <= store_ff[addr];
         status_ff  <= status_in;
         occ_ff     <= rld_pkg::OCC_W'(occ_full);
         del_ok_ff  <= del_ok_in;
      end
   end

   always_comb begin
      rsp_data.status        = status_ff;
      rsp_data.removed_value = del_ok_ff ? rd_data_ff : '0;
      rsp_data.occupancy     = occ_ff;
   end

endmodule

// ===== rtl/core/restricted_linear_deque.sv =====
// Top level of the restricted linear deque: joins the controller and the datapath.
// Depends on rld_pkg, rld_ctrl and rld_datapath.
//
//   Channel  Ports                                   Direction  Moves
//   req      req_valid, req_stall, req_data          in         command and value
//   rsp      rsp_valid, rsp_stall, rsp_data          out        status, removed value, count
//   csr      csr_we, csr_index, csr_wdata            in         capacity, restriction mode
//
// Each transaction is executed in the cycle it is accepted, with one store access;
// its response appears in the output register on the next cycle.
// A new transaction is accepted every cycle while responses are taken.
// Reset empties the deque and loads capacity 128, input restricted; the store is not cleared.
// While a response is stalled, req_stall is raised and no transaction is accepted.
module restricted_linear_deque (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  rld_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output rld_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [rld_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rld_pkg::CAP_W-1:0]     csr_wdata
);

   rld_pkg::dp_cmd_type dp_cmd;

   rld_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_cmd    (dp_cmd)
   );

   rld_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .dp_cmd    (dp_cmd),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

// ===== bench/restricted_linear_deque_test.sv =====
// Self-checking testbench for restricted_linear_deque: directed and random command streams
// are predicted by a behavioral deque and every response is compared field by field.
// Depends on rld_pkg and the restricted_linear_deque RTL.
module restricted_linear_deque_test;
   timeunit 1ns;
   timeprecision 1ps;

   import rld_pkg::*;

   localparam int IDLE_LIMIT  = 2000;
   localparam int MAX_REPORTS = 10;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_style_type;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CAP_W-1:0]     csr_wdata = '0;

   logic [DATA_W-1:0] model_store [DEPTH];
   int                model_front    = 0;
   int                model_rear     = 0;
   bit                model_empty    = 1'b1;
   logic [CAP_W-1:0]  model_capacity = CAPACITY_RESET;
   mode_type          model_mode     = MODE_INPUT_RESTRICTED;

   rsp_type         outcome_q [$];
   int              mismatch_count = 0;
   int              idle_cycles    = 0;
   int              burst_left     = 0;
   int              stall_timer    = 0;
   stall_style_type stall_style    = STALL_NONE;

   restricted_linear_deque dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic rsp_type deque_execute(req_type txn);
      rsp_type res;
      int      usable;
      res = '0;
      res.status = ST_OK;
      if (model_capacity == '0) begin
         usable = 1;
      end else if (int'(model_capacity) > DEPTH) begin
         usable = DEPTH;
      end else begin
         usable = int'(model_capacity);
      end
      if ((txn.command == CMD_INSERT_FRONT && model_mode == MODE_INPUT_RESTRICTED) ||
          (txn.command == CMD_DELETE_REAR && model_mode == MODE_OUTPUT_RESTRICTED)) begin
         res.status = ST_NOT_ALLOWED;
      end else begin
         case (txn.command)
            CMD_INSERT_REAR, CMD_INSERT_FRONT: begin
               if (model_empty) begin
                  model_store[0] = txn.value;
                  model_front    = 0;
                  model_rear     = 0;
                  model_empty    = 1'b0;
               end else if (txn.command == CMD_INSERT_REAR) begin
                  if (model_rear + 1 >= usable) begin
                     res.status = ST_FULL;
                  end else begin
                     model_rear++;
                     model_store[model_rear] = txn.value;
                  end
               end else if (model_front == 0) begin
                  res.status = ST_FULL;
               end else begin
                  model_front--;
                  model_store[model_front] = txn.value;
               end
            end
            default: begin
               if (model_empty) begin
                  res.status = ST_EMPTY;
               end else begin
                  if (txn.command == CMD_DELETE_FRONT) begin
                     res.removed_value = model_store[model_front];
                  end else begin
                     res.removed_value = model_store[model_rear];
                  end
                  if (model_front == model_rear) begin
                     model_empty = 1'b1;
                     model_front = 0;
                     model_rear  = 0;
                  end else if (txn.command == CMD_DELETE_FRONT) begin
                     model_front++;
                  end else begin
                     model_rear--;
                  end
               end
            end
         endcase
      end
      res.occupancy = model_empty ? '0 : OCC_W'(model_rear - model_front + 1);
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type expected;
      if (reset) begin
         model_empty    = 1'b1;
         model_front    = 0;
         model_rear     = 0;
         model_capacity = CAPACITY_RESET;
         model_mode     = MODE_INPUT_RESTRICTED;
         idle_cycles    = 0;
      end else begin
         idle_cycles++;
         if (rsp_valid && !rsp_stall) begin
            idle_cycles = 0;
            if (outcome_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("Unexpected response at %0t: status %0d removed %0d occupancy %0d",
                           $time, rsp_data.status, rsp_data.removed_value,
                           rsp_data.occupancy);
               end
            end else begin
               expected = outcome_q.pop_front();
               if (rsp_data.status !== expected.status ||
                   rsp_data.removed_value !== expected.removed_value ||
                   rsp_data.occupancy !== expected.occupancy) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS) begin
                     $display("Mismatch at %0t: expected status %0d removed %0d occupancy %0d",
                              $time, expected.status, expected.removed_value,
                              expected.occupancy);
                     $display("                   got status %0d removed %0d occupancy %0d",
                              rsp_data.status, rsp_data.removed_value, rsp_data.occupancy);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            idle_cycles = 0;
            outcome_q.push_back(deque_execute(req_data));
         end
         if (csr_we) begin
            case (csr_index)
               CSR_CAPACITY: model_capacity = csr_wdata;
               CSR_MODE:     model_mode     = mode_type'(csr_wdata[0]);
               default:      ;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (stall_timer == 0) begin
         stall_style = stall_style_type'($urandom_range(0, 3));
         stall_timer = $urandom_range(20, 80);
      end
      stall_timer--;
      case (stall_style)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
         default:     rsp_stall <= ~rsp_stall;
      endcase
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic send_txn(cmd_type cmd, logic [DATA_W-1:0] value);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_valid <= 1'b1;
      req_data  <= {cmd, value};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
   endtask

   task automatic drain_outcomes();
      req_valid  <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (outcome_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(csr_idx_type idx, logic [CAP_W-1:0] data);
      drain_outcomes();
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 11))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return '0;
         3:       return '1;
         default: return $urandom();
      endcase
   endfunction

   task automatic test_input_restricted();
      send_txn(CMD_DELETE_FRONT, 32'h1111_1111);
      send_txn(CMD_DELETE_REAR, 32'h2222_2222);
      send_txn(CMD_INSERT_FRONT, 32'h3333_3333);
      send_txn(CMD_INSERT_REAR, 32'h8000_0000);
      send_txn(CMD_INSERT_REAR, 32'h7FFF_FFFF);
      send_txn(CMD_INSERT_REAR, 32'hFFFF_FFFF);
      send_txn(CMD_INSERT_REAR, 32'h0000_0000);
      send_txn(CMD_DELETE_FRONT, '0);
      send_txn(CMD_DELETE_REAR, '0);
      send_txn(CMD_DELETE_REAR, '0);
      send_txn(CMD_DELETE_FRONT, '0);
      send_txn(CMD_DELETE_REAR, '0);
      send_txn(CMD_INSERT_REAR, 32'h5555_5555);
      send_txn(CMD_DELETE_REAR, '1);
      send_txn(CMD_INSERT_REAR, 32'hAAAA_AAAA);
      send_txn(CMD_DELETE_FRONT, '1);
   endtask

   task automatic test_output_restricted();
      write_csr(CSR_MODE, CAP_W'(MODE_OUTPUT_RESTRICTED));
      send_txn(CMD_INSERT_FRONT, 32'h0000_1234);
      send_txn(CMD_INSERT_FRONT, 32'h0000_5678);
      send_txn(CMD_DELETE_REAR, '0);
      send_txn(CMD_INSERT_REAR, 32'hDEAD_BEEF);
      send_txn(CMD_INSERT_REAR, 32'hCAFE_F00D);
      send_txn(CMD_DELETE_FRONT, '0);
      send_txn(CMD_DELETE_FRONT, '0);
      send_txn(CMD_INSERT_FRONT, 32'h0BAD_0001);
      send_txn(CMD_INSERT_FRONT, 32'h0BAD_0002);
      send_txn(CMD_INSERT_FRONT, 32'h0BAD_0003);
      repeat (4) send_txn(CMD_DELETE_FRONT, '0);
   endtask

   task automatic test_capacity_bounds();
      write_csr(CSR_MODE, CAP_W'(MODE_INPUT_RESTRICTED));
      write_csr(CSR_CAPACITY, 8'd1);
      send_txn(CMD_INSERT_REAR, pick_value());
      send_txn(CMD_INSERT_REAR, pick_value());
      send_txn(CMD_DELETE_FRONT, '0);
      write_csr(CSR_CAPACITY, 8'd0);
      send_txn(CMD_INSERT_REAR, pick_value());
      send_txn(CMD_INSERT_REAR, pick_value());
      send_txn(CMD_DELETE_REAR, '0);
      write_csr(CSR_CAPACITY, 8'd2);
      repeat (3) send_txn(CMD_INSERT_REAR, pick_value());
      repeat (2) send_txn(CMD_DELETE_REAR, '0);
   endtask

   task automatic test_capacity_lowered();
      write_csr(CSR_CAPACITY, 8'd128);
      repeat (6) send_txn(CMD_INSERT_REAR, pick_value());
      write_csr(CSR_CAPACITY, 8'd3);
      repeat (5) begin
         send_txn(CMD_INSERT_REAR, pick_value());
         send_txn(CMD_DELETE_REAR, '0);
      end
      repeat (3) send_txn(CMD_DELETE_FRONT, '0);
   endtask

   task automatic test_full_store();
      write_csr(CSR_CAPACITY, 8'd255);
      repeat (DEPTH + 1) send_txn(CMD_INSERT_REAR, pick_value());
      repeat (DEPTH + 1) send_txn(CMD_DELETE_FRONT, '0);
   endtask

   task automatic test_random_traffic();
      int       insert_pct;
      mode_type mode;
      cmd_type  cmd;
      repeat (8) begin
         case ($urandom_range(0, 9))
            0:       write_csr(CSR_CAPACITY, 8'd0);
            1:       write_csr(CSR_CAPACITY, 8'd255);
            2:       write_csr(CSR_CAPACITY, 8'd128);
            3:       write_csr(CSR_CAPACITY, CAP_W'($urandom_range(129, 254)));
            default: write_csr(CSR_CAPACITY, CAP_W'($urandom_range(1, 16)));
         endcase
         mode = mode_type'($urandom_range(0, 1));
         write_csr(CSR_MODE, CAP_W'(mode));
         case ($urandom_range(0, 2))
            0:       insert_pct = 80;
            1:       insert_pct = 50;
            default: insert_pct = 25;
         endcase
         repeat (50) begin
            if ($urandom_range(0, 99) < insert_pct) begin
               if (mode == MODE_OUTPUT_RESTRICTED) begin
                  cmd = $urandom_range(0, 1) ? CMD_INSERT_FRONT : CMD_INSERT_REAR;
               end else begin
                  cmd = ($urandom_range(0, 9) == 0) ? CMD_INSERT_FRONT : CMD_INSERT_REAR;
               end
            end else if (mode == MODE_INPUT_RESTRICTED) begin
               cmd = $urandom_range(0, 1) ? CMD_DELETE_FRONT : CMD_DELETE_REAR;
            end else begin
               cmd = ($urandom_range(0, 9) == 0) ? CMD_DELETE_REAR : CMD_DELETE_FRONT;
            end
            send_txn(cmd, pick_value());
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_input_restricted();
      test_output_restricted();
      test_capacity_bounds();
      test_capacity_lowered();
      test_full_store();
      test_random_traffic();
      drain_outcomes();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && outcome_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
